// ----- rtl/core/jof_pkg.sv -----
// ----------------------------------------------------------------------------
// jof_pkg
// Shared constants and types for the JSON object framer.
// ----------------------------------------------------------------------------
package jof_pkg;

   localparam int DEPTH_BITS = 16;
   localparam int LEN_BITS   = 21;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0]   LEN_RESET = LEN_BITS'(1024 * 1024);

   localparam logic [7:0] CH_OPEN   = 8'h7B;
   localparam logic [7:0] CH_CLOSE  = 8'h7D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;

   // Sideband flags of one result, packed highest bit first.
   typedef struct packed {
      logic object_keep;
      logic object_end;
      logic object_start;
      logic byte_valid;
   } rsp_flags_type;

endpackage

// ----- rtl/core/json_object_framer_top.sv -----
// ----------------------------------------------------------------------------
// json_object_framer_top
// Frames top-level JSON objects in a raw byte stream by brace depth.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and shows its result in the cycle after the
// transaction that carried the byte; the scanner state (depth, string and
// escape flags, length counter) is updated in the same cycle as the byte is
// taken, so bytes may arrive back to back. A single output register holds a
// result; a new byte is taken while that register is empty or being emptied.
// Bytes outside an object and bytes of a dropped object produce no result,
// except the closing brace of a dropped object, which still flags the end.
// The maximum object length may only be written while the block is idle.
module json_object_framer_top (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic [3:0]  rsp_tuser,    // [0] byte_valid, [1] object_start,
                                     // [2] object_end, [3] object_keep
   // Configuration.
   input  logic        csr_wr_en,
   input  logic [jof_pkg::LEN_BITS-1:0] csr_wr_data  // max_record_len
);
   import jof_pkg::*;

   logic [LEN_BITS-1:0]   max_len_ff;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                  in_str_ff, in_str_in;
   logic                  esc_ff, esc_in;
   logic                  drop_ff, drop_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   rsp_flags_type         rsp_flags_ff, rsp_flags_in;

   logic                  accept;
   logic                  emit;
   logic                  byte_ok;
   logic                  drop_nx;
   logic                  obj_end;
   logic [DEPTH_BITS-1:0] depth_dec;
   logic [7:0]            b;

   assign b          = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign depth_dec  = depth_ff - DEPTH_BITS'(1);

   always_comb begin
      depth_in     = depth_ff;
      in_str_in    = in_str_ff;
      esc_in       = esc_ff;
      drop_in      = drop_ff;
      len_in       = len_ff;
      emit         = 1'b0;
      byte_ok      = !drop_ff;
      drop_nx      = drop_ff;
      obj_end      = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_flags_in = rsp_flags_ff;

      if (accept) begin
         if (depth_ff == '0) begin
            if (b == CH_OPEN) begin
               depth_in     = DEPTH_BITS'(1);
               len_in       = LEN_BITS'(1);
               drop_in      = 1'b0;
               emit         = 1'b1;
               rsp_byte_in  = b;
               rsp_flags_in = '{object_keep: 1'b0, object_end: 1'b0,
                                object_start: 1'b1, byte_valid: 1'b1};
            end
         end else begin
            // The length test uses the count before this byte is added.
            if (byte_ok) begin
               if (len_ff >= max_len_ff) begin
                  drop_nx = 1'b1;
               end
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + LEN_BITS'(1);
               end
            end

            priority if (in_str_ff) begin
               priority if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (b == CH_BSLASH) begin
                  esc_in = 1'b1;
               end else if (b == CH_QUOTE) begin
                  in_str_in = 1'b0;
               end else begin
                  in_str_in = in_str_ff;
               end
            end else if (b == CH_QUOTE) begin
               in_str_in = 1'b1;
            end else if (b == CH_OPEN) begin
               if (depth_ff != DEPTH_MAX) begin
                  depth_in = depth_ff + DEPTH_BITS'(1);
               end
            end else if (b == CH_CLOSE) begin
               depth_in = depth_dec;
               obj_end  = (depth_dec == '0);
            end else begin
               depth_in = depth_ff;
            end

            drop_in = drop_nx;
            if (obj_end) begin
               len_in       = '0;
               in_str_in    = 1'b0;
               esc_in       = 1'b0;
               drop_in      = 1'b0;
               emit         = 1'b1;
               rsp_byte_in  = byte_ok ? b : 8'h00;
               rsp_flags_in = '{object_keep: !drop_nx, object_end: 1'b1,
                                object_start: 1'b0, byte_valid: byte_ok};
            end else if (byte_ok) begin
               emit         = 1'b1;
               rsp_byte_in  = b;
               rsp_flags_in = '{object_keep: 1'b0, object_end: 1'b0,
                                object_start: 1'b0, byte_valid: 1'b1};
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= LEN_RESET;
         depth_ff     <= '0;
         in_str_ff    <= 1'b0;
         esc_ff       <= 1'b0;
         drop_ff      <= 1'b0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         depth_ff     <= depth_in;
         in_str_ff    <= in_str_in;
         esc_ff       <= esc_in;
         drop_ff      <= drop_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff  <= rsp_byte_in;
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_flags_ff;

`ifndef SYNTHESIS
   a_start_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_flags_ff.object_start && rsp_flags_ff.object_end))
      else $error("object start and end flagged on one transaction");

   a_keep_needs_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.object_keep) |-> rsp_flags_ff.object_end)
      else $error("object_keep set without object_end");

   a_start_is_brace: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.object_start) |->
         (rsp_byte_ff == CH_OPEN && depth_ff != '0))
      else $error("object start on a byte other than an opening brace");

   a_idle_skip: assert property (@(posedge clock) disable iff (reset)
      (accept && depth_ff == '0 && b != CH_OPEN) |-> (!emit ##1 depth_ff == '0))
      else $error("byte outside an object changed the scanner");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && obj_end) |=> (len_ff == '0 && !drop_ff && !in_str_ff))
      else $error("object end did not clear the scanner state");
`endif

endmodule
